@@ src/assert_macros.svh @@
// assertion macros used by the loop period statistics rtl
// depends on nothing; wrap concurrent assertions on a clock and active-low reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/lpps_pkg.sv @@
// shared types and constants for the loop period statistics block
// no dependencies
package lpps_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned TOTAL_W = 10;
  localparam int unsigned AVG_W   = 36;
  localparam int unsigned FRAC_W  = 4;

  localparam int unsigned PCT_A     = 95;
  localparam int unsigned PCT_B     = 99;
  localparam int unsigned PCT_DIV   = 100;

  // x * RECIP >> RECIP_SH is the exact floor of x / PCT_DIV for x below 1.8 million
  localparam int unsigned RECIP_SH = 26;
  localparam int unsigned RECIP    = ((1 << RECIP_SH) + PCT_DIV - 1) / PCT_DIV;
  localparam int unsigned RECIP_A  = PCT_A * RECIP;
  localparam int unsigned RECIP_B  = PCT_B * RECIP;

  localparam int unsigned BIT_W = 5;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_QUERY  = 1'b1
  } req_e;

  localparam int unsigned NUM_RANKS = 5;
  localparam int unsigned RANK_W    = 3;

  localparam logic [RANK_W-1:0] RANK_MIN = 3'd0;
  localparam logic [RANK_W-1:0] RANK_MED = 3'd1;
  localparam logic [RANK_W-1:0] RANK_P95 = 3'd2;
  localparam logic [RANK_W-1:0] RANK_P99 = 3'd3;
  localparam logic [RANK_W-1:0] RANK_MAX = 3'd4;

endpackage

@@ src/lpps_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
module lpps_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 512,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/lpps_div.sv @@
// restoring divider, one quotient bit per cycle
// no dependencies; started by a one-cycle pulse, done pulses with the quotient
module lpps_div #(
  parameter int unsigned DW = 46,
  parameter int unsigned VW = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic [DW-1:0] quo_q;
  logic [VW-1:0] rem_q;
  logic [VW-1:0] dvs_q;
  logic [CW-1:0] cnt_q;
  logic          run_q;
  logic          done_q;

  logic [VW:0]   rem_shift;
  logic [VW:0]   rem_diff;
  logic          take;
  logic [VW-1:0] rem_next;

  always_comb begin
    rem_shift = {rem_q, quo_q[DW-1]};
    rem_diff  = rem_shift - {1'b0, dvs_q};
    take      = (rem_shift >= {1'b0, dvs_q});
    rem_next  = take ? rem_diff[VW-1:0] : rem_shift[VW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        quo_q <= dividend_i;
        rem_q <= '0;
        dvs_q <= divisor_i;
        cnt_q <= CW'(DW);
        run_q <= 1'b1;
      end else if (run_q) begin
        rem_q <= rem_next;
        quo_q <= {quo_q[DW-2:0], take};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ src/loop_period_percentile_stats.sv @@
// loop period statistics: interval ring, radix selection of order statistics
// depends on lpps_pkg, lpps_ram, lpps_div and assert_macros.svh
//
// usage:
//   one input channel (start/busy) carries items: req_type_i selects a timestamp
//   sample or a statistics query. an item is taken at a rising edge with start
//   high and busy low.
//   a sample is absorbed at its accept edge and yields no result; busy stays low,
//   so samples may follow every cycle.
//   a query on an empty window gives its result strobe in the cycle after accept.
//   otherwise the percentile ranks come from a reciprocal multiply at accept,
//   then one summing pass, one division on the restoring divider
//   (dividend width DW = 36 + count bits) and 160 radix selection passes over
//   the n held intervals, each pass a sweep of the ram read port; busy stays
//   high through all of them and the result strobe follows the last pass.
//   result_valid_o marks each result for exactly one cycle; the receiver cannot
//   stall, and busy is already low in that cycle.
//   reset clears the count, pointer and previous timestamp; ram contents are not
//   cleared and never read before they are written.
`include "assert_macros.svh"

module loop_period_percentile_stats #(
  parameter int unsigned WINDOW_DEPTH = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        req_type_i,
  input  logic [31:0] time_us_i,
  output logic        result_valid_o,
  output logic [9:0]  sample_total_o,
  output logic [31:0] min_period_o,
  output logic [31:0] median_period_o,
  output logic [31:0] p95_period_o,
  output logic [31:0] p99_period_o,
  output logic [31:0] max_period_o,
  output logic [35:0] avg_period_q4_o
);

  localparam int unsigned DATA_W  = lpps_pkg::DATA_W;
  localparam int unsigned TOTAL_W = lpps_pkg::TOTAL_W;
  localparam int unsigned BIT_W   = lpps_pkg::BIT_W;
  localparam int unsigned RANK_W  = lpps_pkg::RANK_W;
  localparam int unsigned AW      = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SUM_W   = DATA_W + CNT_W;
  localparam int unsigned DW      = SUM_W + lpps_pkg::FRAC_W;
  localparam int unsigned PROD_W  = CNT_W + lpps_pkg::RECIP_SH;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_AVG,
    ST_SEL
  } state_e;

  state_e                         state_q;
  logic [DATA_W-1:0]              last_q;
  logic [AW-1:0]                  wp_q;
  logic [CNT_W-1:0]               count_q;
  logic [CNT_W-1:0]               iss_q;
  logic                           rd_vld_q;
  logic [SUM_W-1:0]               sum_q;
  logic [CNT_W-1:0]               q95_q;
  logic [CNT_W-1:0]               q99_q;
  logic [CNT_W-1:0]               rank_q;
  logic [CNT_W-1:0]               cnt_q;
  logic [DATA_W-1:0]              prefix_q;
  logic [BIT_W-1:0]               bit_q;
  logic [RANK_W-1:0]              rsel_q;
  logic                           div_start_q;
  logic                           valid_q;
  logic [TOTAL_W-1:0]             total_q;
  logic [lpps_pkg::AVG_W-1:0]     avg_q;
  logic [DATA_W-1:0]              res_q [lpps_pkg::NUM_RANKS];

  logic                           accept;
  logic                           run_query;
  logic                           ram_we;
  logic [DATA_W-1:0]              ram_wdata;
  logic [DATA_W-1:0]              ram_rdata;
  logic                           scanning;
  logic                           issue;
  logic                           scan_end;
  logic [DATA_W-1:0]              hi_mask;
  logic [DATA_W-1:0]              bit_mask;
  logic                           sel_hit;
  logic                           take_zero;
  logic [DATA_W-1:0]              fin_prefix;
  logic [RANK_W-1:0]              rsel_nx;
  logic [CNT_W-1:0]               rank_nx;
  logic [PROD_W-1:0]              prod95;
  logic [PROD_W-1:0]              prod99;
  logic [DW-1:0]                  div_dividend;
  logic [CNT_W-1:0]               div_divisor;
  logic                           div_done;
  logic [DW-1:0]                  div_quo;

  // ring write and scan control
  always_comb begin
    busy      = (state_q != ST_IDLE);
    accept    = start && !busy;
    run_query = accept && (req_type_i == lpps_pkg::REQ_QUERY) && (count_q != '0);
    ram_we    = accept && (req_type_i == lpps_pkg::REQ_SAMPLE) && (last_q != '0);
    ram_wdata = time_us_i - last_q;
    scanning  = (state_q == ST_SUM) || (state_q == ST_SEL);
    issue     = scanning && (iss_q != count_q);
    scan_end  = scanning && (iss_q == count_q) && !rd_vld_q;
  end

  // percentile ranks n*95/100 and n*99/100 by reciprocal multiplication
  always_comb begin
    prod95 = PROD_W'(count_q) * PROD_W'(lpps_pkg::RECIP_A);
    prod99 = PROD_W'(count_q) * PROD_W'(lpps_pkg::RECIP_B);
  end

  // one radix step: count held values that match the current prefix above this bit and have this bit clear
  always_comb begin
    hi_mask    = ~({DATA_W{1'b1}} >> (BIT_W'(DATA_W - 1) - bit_q));
    bit_mask   = DATA_W'(1) << bit_q;
    sel_hit    = (((ram_rdata ^ prefix_q) & hi_mask) == '0) && !ram_rdata[bit_q];
    take_zero  = (rank_q < cnt_q);
    fin_prefix = take_zero ? prefix_q : (prefix_q | bit_mask);
  end

  // target rank of the next statistic
  always_comb begin
    rsel_nx = (state_q == ST_AVG) ? lpps_pkg::RANK_MIN : rsel_q + 1'b1;
    case (rsel_nx)
      lpps_pkg::RANK_MIN: rank_nx = '0;
      lpps_pkg::RANK_MED: rank_nx = count_q >> 1;
      lpps_pkg::RANK_P95: rank_nx = q95_q;
      lpps_pkg::RANK_P99: rank_nx = q99_q;
      lpps_pkg::RANK_MAX: rank_nx = count_q - 1'b1;
      default:            rank_nx = '0;
    endcase
  end

  // average operands for the divider
  always_comb begin
    div_dividend = {sum_q, {lpps_pkg::FRAC_W{1'b0}}};
    div_divisor  = count_q;
  end

  lpps_ram #(
    .WIDTH (DATA_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (ram_wdata),
    .raddr_i (iss_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  lpps_div #(
    .DW (DW),
    .VW (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      last_q      <= '0;
      wp_q        <= '0;
      count_q     <= '0;
      iss_q       <= '0;
      rd_vld_q    <= 1'b0;
      sum_q       <= '0;
      q95_q       <= '0;
      q99_q       <= '0;
      rank_q      <= '0;
      cnt_q       <= '0;
      prefix_q    <= '0;
      bit_q       <= '0;
      rsel_q      <= '0;
      div_start_q <= 1'b0;
      valid_q     <= 1'b0;
      total_q     <= '0;
      avg_q       <= '0;
      for (int i = 0; i < lpps_pkg::NUM_RANKS; i++) begin
        res_q[i] <= '0;
      end
    end else begin
      valid_q     <= 1'b0;
      div_start_q <= 1'b0;
      rd_vld_q    <= issue;
      if (issue) begin
        iss_q <= iss_q + 1'b1;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (req_type_i == lpps_pkg::REQ_SAMPLE) begin
              if (last_q != '0) begin
                wp_q <= (wp_q == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_q + 1'b1;
                if (count_q != CNT_W'(WINDOW_DEPTH)) begin
                  count_q <= count_q + 1'b1;
                end
              end
              last_q <= time_us_i;
            end else begin
              total_q <= TOTAL_W'(count_q);
              if (count_q == '0) begin
                avg_q   <= '0;
                valid_q <= 1'b1;
                for (int i = 0; i < lpps_pkg::NUM_RANKS; i++) begin
                  res_q[i] <= '0;
                end
              end else begin
                q95_q   <= prod95[PROD_W-1:lpps_pkg::RECIP_SH];
                q99_q   <= prod99[PROD_W-1:lpps_pkg::RECIP_SH];
                sum_q   <= '0;
                iss_q   <= '0;
                state_q <= ST_SUM;
              end
            end
          end
        end
        ST_SUM: begin
          if (rd_vld_q) begin
            sum_q <= sum_q + SUM_W'(ram_rdata);
          end
          if (scan_end) begin
            div_start_q <= 1'b1;
            state_q     <= ST_AVG;
          end
        end
        ST_AVG: begin
          if (div_done) begin
            avg_q    <= div_quo[lpps_pkg::AVG_W-1:0];
            rsel_q   <= rsel_nx;
            rank_q   <= rank_nx;
            prefix_q <= '0;
            bit_q    <= BIT_W'(DATA_W - 1);
            cnt_q    <= '0;
            iss_q    <= '0;
            state_q  <= ST_SEL;
          end
        end
        ST_SEL: begin
          if (rd_vld_q && sel_hit) begin
            cnt_q <= cnt_q + 1'b1;
          end
          if (scan_end) begin
            cnt_q <= '0;
            iss_q <= '0;
            if (bit_q == '0) begin
              res_q[rsel_q] <= fin_prefix;
              if (rsel_q == lpps_pkg::RANK_MAX) begin
                valid_q <= 1'b1;
                state_q <= ST_IDLE;
              end else begin
                rsel_q   <= rsel_nx;
                rank_q   <= rank_nx;
                prefix_q <= '0;
                bit_q    <= BIT_W'(DATA_W - 1);
              end
            end else begin
              prefix_q <= fin_prefix;
              if (!take_zero) begin
                rank_q <= rank_q - cnt_q;
              end
              bit_q <= bit_q - 1'b1;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign result_valid_o  = valid_q;
  assign sample_total_o  = total_q;
  assign min_period_o    = res_q[lpps_pkg::RANK_MIN];
  assign median_period_o = res_q[lpps_pkg::RANK_MED];
  assign p95_period_o    = res_q[lpps_pkg::RANK_P95];
  assign p99_period_o    = res_q[lpps_pkg::RANK_P99];
  assign max_period_o    = res_q[lpps_pkg::RANK_MAX];
  assign avg_period_q4_o = avg_q;

  `ASSERT_NEXT(a_query_busy, clk_i, rst_ni, run_query, busy, "query did not raise busy")
  `ASSERT_IMPLY(a_result_idle, clk_i, rst_ni, result_valid_o, !busy, "result shown while busy")
  `ASSERT_IMPLY(a_read_in_scan, clk_i, rst_ni, rd_vld_q, scanning, "ram read data outside a scan")
  `ASSERT_NEXT(a_count_hold, clk_i, rst_ni, busy, $stable(count_q), "count changed in a query")

endmodule
